/* sv/stsc_pkg.sv */
package stsc_pkg;

  // Token kinds
  localparam logic [4:0] K_IDENT  = 5'd0;
  localparam logic [4:0] K_INT    = 5'd1;
  localparam logic [4:0] K_FLOAT  = 5'd2;
  localparam logic [4:0] K_STRING = 5'd3;
  localparam logic [4:0] K_COLON  = 5'd5;
  localparam logic [4:0] K_EQUAL  = 5'd6;
  localparam logic [4:0] K_SEMI   = 5'd7;
  localparam logic [4:0] K_END    = 5'd15;
  localparam logic [4:0] K_ERROR  = 5'd16;

  // Error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNTERM  = 2'd1;
  localparam logic [1:0] E_BADCHAR = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;

  localparam logic [23:0] POS_MAX = 24'hFFFFFF;
  localparam int          NUM_KW  = 8;

  // Keywords, first character in the lowest byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_656C,   // let
    64'h0000_0000_6575_7274,   // true
    64'h0000_0065_736C_6166,   // false
    64'h0000_0000_6C6C_756E,   // null
    64'h0000_0000_0074_6E69,   // int
    64'h0000_0074_616F_6C66,   // float
    64'h0000_0000_6C6F_6F62,   // bool
    64'h0000_676E_6972_7473    // string
  };
  localparam logic [3:0] KW_LEN  [NUM_KW] = '{4'd3, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd6};
  localparam logic [4:0] KW_KIND [NUM_KW] = '{5'd4, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
                                              5'd14};

  // One token on its way out
  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [23:0] line;
    logic [23:0] col;
    logic [62:0] ival;
    logic [1:0]  err;
    logic [7:0]  bad;
  } tok_t;

  // Tokens closed by one byte
  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } burst_t;

  // Scanner status
  typedef struct packed {
    logic done;
    logic err_seen;
  } stat_t;

endpackage

/* sv/stsc_scan.sv */
module stsc_scan #(
  parameter int OFFSET_BITS   = 24,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [7:0]     src_byte,
  output stsc_pkg::burst_t bst,
  output stsc_pkg::stat_t  st
);
  import stsc_pkg::*;

  localparam int KW_BITS = 8 * KEYWORD_CHARS;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_INT    = 3'd2;
  localparam logic [2:0] M_INTDOT = 3'd3;
  localparam logic [2:0] M_FLOAT  = 3'd4;
  localparam logic [2:0] M_STRING = 3'd5;
  localparam logic [2:0] M_DONE   = 3'd6;

  logic [2:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [23:0]            line_r, line_nxt;
  logic [23:0]            col_r, col_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [23:0]            tline_r, tline_nxt;
  logic [23:0]            tcol_r, tcol_nxt;
  logic [KW_BITS-1:0]     kwbuf_r, kwbuf_nxt;
  logic [62:0]            dval_r, dval_nxt;
  logic                   err_r, err_nxt;

  function automatic tok_t mk_tok(logic [4:0] kind, logic [23:0] start, logic [23:0] len,
                                  logic [23:0] line, logic [23:0] col, logic [62:0] ival,
                                  logic [1:0] err, logic [7:0] bad);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    t.ival  = ival;
    t.err   = err;
    t.bad   = bad;
    return t;
  endfunction

  // Character classes
  logic is_alpha, is_digit, is_space;
  assign is_alpha = (src_byte >= CH_LOA && src_byte <= CH_LOZ) ||
                    (src_byte >= CH_UPA && src_byte <= CH_UPZ) || src_byte == CH_UNDER;
  assign is_digit = src_byte >= CH_ZERO && src_byte <= CH_NINE;
  assign is_space = src_byte == CH_SPACE || src_byte == CH_TAB || src_byte == CH_CR ||
                    src_byte == CH_VT || src_byte == CH_FF;

  // Saturating decimal accumulate
  logic [66:0] prod;
  logic [62:0] dval_acc;
  assign prod     = ({4'b0, dval_r} << 3) + ({4'b0, dval_r} << 1) +
                    67'(src_byte - CH_ZERO);
  assign dval_acc = (prod[66:63] != 4'b0) ? {63{1'b1}} : prod[62:0];

  // Keyword match on the buffered identifier
  logic [OFFSET_BITS-1:0] cur_len;
  logic [4:0]             id_kind;
  assign cur_len = off_r - tstart_r;

  always_comb begin
    id_kind = K_IDENT;
    if (cur_len <= OFFSET_BITS'(KEYWORD_CHARS)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (cur_len == OFFSET_BITS'(KW_LEN[i]) && kwbuf_r == KW_TEXT[i][KW_BITS-1:0])
          id_kind = KW_KIND[i];
      end
    end
  end

  // Per-byte scan: tokens closed by the current mode, then the byte rescanned from idle if not consumed
  logic [1:0]             pre_n;
  logic                   rescan;
  logic                   adv;
  logic [OFFSET_BITS-1:0] dot_off;
  logic [OFFSET_BITS-1:0] int_len;
  logic [23:0]            dot_col;

  assign dot_off = off_r - OFFSET_BITS'(1);
  // integer length up to the held dot, wrapping with the offset
  assign int_len = dot_off - tstart_r;
  assign dot_col = (col_r > 24'd1) ? col_r - 24'd1 : 24'd1;

  always_comb begin
    bst        = '0;
    pre_n      = 2'd0;
    rescan     = 1'b0;
    adv        = 1'b0;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    kwbuf_nxt  = kwbuf_r;
    dval_nxt   = dval_r;
    err_nxt    = err_r;

    case (mode_r)
      M_IDENT: begin
        if (is_alpha || is_digit) begin
          for (int k = 0; k < KEYWORD_CHARS; k++) begin
            if (cur_len == OFFSET_BITS'(k))
              kwbuf_nxt[8*k +: 8] = kwbuf_r[8*k +: 8] | src_byte;
          end
          adv = 1'b1;
        end else begin
          bst.tok[0] = mk_tok(id_kind, 24'(tstart_r), 24'(cur_len), tline_r, tcol_r,
                              '0, E_NONE, '0);
          pre_n  = 2'd1;
          rescan = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit) begin
          dval_nxt = dval_acc;
          adv      = 1'b1;
        end else if (src_byte == CH_DOT) begin
          mode_nxt = M_INTDOT;
          adv      = 1'b1;
        end else begin
          bst.tok[0] = mk_tok(K_INT, 24'(tstart_r), 24'(cur_len), tline_r, tcol_r,
                              dval_r, E_NONE, '0);
          pre_n  = 2'd1;
          rescan = 1'b1;
        end
      end
      M_INTDOT: begin
        if (is_digit) begin
          mode_nxt = M_FLOAT;
          adv      = 1'b1;
        end else begin
          // integer without the held dot, then the lone dot as an error
          bst.tok[0] = mk_tok(K_INT, 24'(tstart_r), 24'(int_len), tline_r,
                              tcol_r, dval_r, E_NONE, '0);
          bst.tok[1] = mk_tok(K_ERROR, 24'(dot_off), 24'd1, line_r, dot_col, '0,
                              E_BADCHAR, CH_DOT);
          err_nxt = 1'b1;
          pre_n   = 2'd2;
          rescan  = 1'b1;
        end
      end
      M_FLOAT: begin
        if (is_digit) begin
          adv = 1'b1;
        end else begin
          bst.tok[0] = mk_tok(K_FLOAT, 24'(tstart_r), 24'(cur_len), tline_r, tcol_r,
                              '0, E_NONE, '0);
          pre_n  = 2'd1;
          rescan = 1'b1;
        end
      end
      M_STRING: begin
        if (src_byte == CH_QUOTE) begin
          bst.tok[0] = mk_tok(K_STRING, 24'(tstart_r), 24'(cur_len), tline_r, tcol_r,
                              '0, E_NONE, '0);
          pre_n    = 2'd1;
          mode_nxt = M_IDLE;
          adv      = 1'b1;
        end else if (src_byte == CH_NUL) begin
          bst.tok[0] = mk_tok(K_ERROR, 24'(tstart_r), 24'(cur_len), tline_r, tcol_r,
                              '0, E_UNTERM, '0);
          err_nxt = 1'b1;
          pre_n   = 2'd1;
          rescan  = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end
      M_DONE: begin
        // every byte after the end repeats the end token
        bst.tok[0] = mk_tok(K_END, 24'(off_r), 24'd0, line_r, col_r, '0, E_NONE, '0);
        pre_n      = 2'd1;
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    bst.cnt = pre_n;

    // Byte seen from the idle mode
    if (rescan) begin
      mode_nxt = M_IDLE;
      adv      = 1'b1;
      if (src_byte == CH_NUL) begin
        bst.tok[pre_n] = mk_tok(K_END, 24'(off_r), 24'd0, line_r, col_r, '0, E_NONE, '0);
        bst.cnt        = pre_n + 2'd1;
        mode_nxt       = M_DONE;
        adv            = 1'b0;
      end else if (is_alpha) begin
        tstart_nxt = off_r;
        tline_nxt  = line_r;
        tcol_nxt   = col_r;
        kwbuf_nxt  = KW_BITS'(src_byte);
        mode_nxt   = M_IDENT;
      end else if (is_digit) begin
        tstart_nxt = off_r;
        tline_nxt  = line_r;
        tcol_nxt   = col_r;
        dval_nxt   = 63'(src_byte - CH_ZERO);
        mode_nxt   = M_INT;
      end else if (src_byte == CH_QUOTE) begin
        tstart_nxt = off_r;
        tline_nxt  = line_r;
        tcol_nxt   = col_r;
        mode_nxt   = M_STRING;
      end else if (src_byte == CH_COLON || src_byte == CH_EQUAL || src_byte == CH_SEMI) begin
        bst.tok[pre_n] = mk_tok((src_byte == CH_COLON) ? K_COLON :
                                (src_byte == CH_EQUAL) ? K_EQUAL : K_SEMI,
                                24'(off_r), 24'd1, line_r, col_r, '0, E_NONE, '0);
        bst.cnt        = pre_n + 2'd1;
      end else if (!is_space && src_byte != CH_LF) begin
        bst.tok[pre_n] = mk_tok(K_ERROR, 24'(off_r), 24'd1, line_r, col_r, '0,
                                E_BADCHAR, src_byte);
        bst.cnt        = pre_n + 2'd1;
        err_nxt        = 1'b1;
      end
    end

    // Position advance
    off_nxt  = off_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (adv) begin
      off_nxt = off_r + OFFSET_BITS'(1);
      if (src_byte == CH_LF) begin
        line_nxt = (line_r != POS_MAX) ? line_r + 24'd1 : line_r;
        col_nxt  = 24'd1;
      end else if (col_r != POS_MAX) begin
        col_nxt = col_r + 24'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      off_r    <= '0;
      line_r   <= 24'd1;
      col_r    <= 24'd1;
      tstart_r <= '0;
      tline_r  <= 24'd1;
      tcol_r   <= 24'd1;
      kwbuf_r  <= '0;
      dval_r   <= '0;
      err_r    <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      kwbuf_r  <= kwbuf_nxt;
      dval_r   <= dval_nxt;
      err_r    <= err_nxt;
    end
  end

  assign st.done     = mode_r == M_DONE;
  assign st.err_seen = err_r;

endmodule

/* sv/stsc_obuf.sv */
module stsc_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  stsc_pkg::burst_t bst,
  input  logic             out_stall,
  output logic             out_valid,
  output stsc_pkg::tok_t   cur,
  output logic             last,
  output logic             room
);
  import stsc_pkg::*;

  tok_t [2:0] tok_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       take;

  assign out_valid = cnt_r != 2'd0;
  assign cur       = tok_r[idx_r];
  assign last      = idx_r == cnt_r - 2'd1;
  assign take      = out_valid && !out_stall;
  // free once the final token of the held burst is taken
  assign room      = !out_valid || (take && last);

  // Token payload
  always_ff @(posedge clk) begin
    if (load)
      tok_r <= bst.tok;
  end

  // Burst count and read index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bst.cnt;
      idx_r <= 2'd0;
    end else if (take) begin
      if (last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

/* sv/source_token_scanner.sv */
// Streaming source scanner: one source byte per request on the in_ channel,
// one token per request on the out_ channel. Byte 0 ends the source; every
// later byte gives another end token at the same position.
// A request is taken when valid is high and stall is low. Tokens closed by a
// byte appear on out_ the cycle after that byte is taken. Throughput is one
// byte per cycle while out_stall is low and each byte closes at most one token.
// A byte can close up to three tokens; they leave one per cycle from the
// result register while out_stall is low, and in_stall stays high until the
// last of them is taken. out_last_of_run marks the last token a byte produced.
// While out_stall is high the current token holds; in_stall rises once a
// token is held, freeing in the cycle its final token is taken.
// Reset (rst_n low, synchronous) empties the result register and returns the
// scanner to offset 0, line 1, column 1, between tokens.
module source_token_scanner #(
  parameter int OFFSET_BITS   = 24,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_src_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [23:0] out_start_offset,
  output logic [23:0] out_token_length,
  output logic [23:0] out_start_line,
  output logic [23:0] out_start_column,
  output logic [62:0] out_int_value,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_bad_byte,
  output logic        out_last_of_run
);
  import stsc_pkg::*;

  burst_t bst;
  stat_t  st;
  tok_t   cur;
  logic   acc;
  logic   room;

  assign in_stall = !room;
  assign acc      = in_valid && room;

  stsc_scan #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .src_byte (in_src_byte),
    .bst      (bst),
    .st       (st)
  );

  stsc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc && bst.cnt != 2'd0),
    .bst       (bst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cur       (cur),
    .last      (out_last_of_run),
    .room      (room)
  );

  assign out_token_kind   = cur.kind;
  assign out_start_offset = cur.start;
  assign out_token_length = cur.len;
  assign out_start_line   = cur.line;
  assign out_start_column = cur.col;
  assign out_int_value    = cur.ival;
  assign out_error_code   = cur.err;
  assign out_bad_byte     = cur.bad;

  // An error token on the output means the sticky flag is already set
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_ERROR |-> st.err_seen)
    else $error("error token without sticky error flag");

  // Only error tokens carry an error code
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != E_NONE |-> out_token_kind == K_ERROR)
    else $error("error code on a non-error token");

  // An end token is only seen once the scanner has finished
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_END |-> st.done)
    else $error("end token while scanner still active");

  // Once finished, the scanner stays finished
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |=> st.done)
    else $error("scanner left the finished state");

endmodule
